/* hdl/escape_sequence_decoder_macros.svh */
// Assertion macros shared by the checker.
`ifndef ESCAPE_SEQUENCE_DECODER_MACROS_SVH
`define ESCAPE_SEQUENCE_DECODER_MACROS_SVH

// Implication in the same cycle, off during reset.
`define ESD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication in the next cycle, off during reset.
`define ESD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Implication in the next cycle, checked through reset too.
`define ESD_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/esd_pkg.sv */
`timescale 1ns / 1ps

package esd_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESCAPE = 3'd1,
    MODE_HEX_HI = 3'd2,
    MODE_HEX_LO = 3'd3,
    MODE_CARET  = 3'd4
  } mode_t;

  localparam logic [7:0] CHAR_NUL       = 8'h00;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_CARET     = 8'h5E;
  localparam logic [7:0] CHAR_X         = 8'h78;
  localparam logic [7:0] CHAR_S         = 8'h73;
  localparam logic [7:0] CHAR_E         = 8'h65;
  localparam logic [7:0] CHAR_B         = 8'h62;
  localparam logic [7:0] CHAR_N         = 8'h6E;
  localparam logic [7:0] CHAR_R         = 8'h72;
  localparam logic [7:0] CHAR_T         = 8'h74;

  localparam logic [7:0] BYTE_SPACE     = 8'h20;
  localparam logic [7:0] BYTE_ESC       = 8'd27;
  localparam logic [7:0] BYTE_BS        = 8'd8;
  localparam logic [7:0] BYTE_LF        = 8'd10;
  localparam logic [7:0] BYTE_CR        = 8'd13;
  localparam logic [7:0] BYTE_TAB       = 8'd9;

  typedef struct packed {
    logic       emit;
    logic [7:0] data;
    logic       last;
  } result_t;

  // '0'..'9' -> 0..9, letters of either case -> 10..35, anything else -> 0
  function automatic logic [5:0] digit_value(input logic [7:0] ch);
    logic [7:0] diff;
    begin
      diff = 8'h00;
      if (ch >= 8'h30 && ch <= 8'h39) begin
        diff = ch - 8'h30;
      end else if (ch >= 8'h61 && ch <= 8'h7A) begin
        diff = ch - 8'h61 + 8'd10;
      end else if (ch >= 8'h41 && ch <= 8'h5A) begin
        diff = ch - 8'h41 + 8'd10;
      end
      return diff[5:0];
    end
  endfunction

endpackage

/* hdl/escape_sequence_decoder.sv */
`timescale 1ns / 1ps
// Escape sequence decoder.
// Input stream (s_*): one text byte per transfer. A backslash opens an escape
// (\x plus two digits, \\, \^, \s, \e, \b, \n, \r, \t); a caret turns the next
// byte into a control code; a zero byte ends the string.
// Output stream (m_*): one decoded byte per transfer; m_tlast marks the
// terminator produced by a zero input byte, with m_tdata zero.
// Bytes that open an escape or caret sequence, the x and first digit of a
// hex escape, and unknown escape letters produce no output transfer.
// Path: a taken byte is held in the input register, decoded by combinational
// logic, and its result is registered in the output register behind m_tvalid.
// Throughput: one byte per cycle unless the output stalls; the decode is a
// single pass of logic between the input register and the output register.
// Reset (rst, synchronous) empties both registers and returns the decoder
// to normal mode. When m_tready is low the output register holds its
// transfer; an empty input register still takes one byte, then s_tready
// stays low until the output drains.
module escape_sequence_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] text_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] decoded_byte
  output logic       m_tlast
);

  import esd_pkg::*;

  logic       advance;
  logic       in_valid;
  logic [7:0] in_byte;
  result_t    res;

  esd_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .advance  (advance),
    .in_valid (in_valid),
    .in_byte  (in_byte)
  );

  esd_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .advance  (advance),
    .res      (res)
  );

  esd_out_stage u_out_stage (
    .clk      (clk),
    .rst      (rst),
    .res      (res),
    .advance  (advance),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

/* hdl/esd_in_stage.sv */
`timescale 1ns / 1ps

module esd_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       advance,
  output logic       in_valid,
  output logic [7:0] in_byte
);

  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

endmodule

/* hdl/esd_decode.sv */
`timescale 1ns / 1ps

module esd_decode (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [7:0]      in_byte,
  input  logic            advance,
  output esd_pkg::result_t res
);

  import esd_pkg::*;

  mode_t      mode;
  mode_t      mode_next;
  logic [7:0] partial_hex;
  logic [7:0] partial_hex_next;
  logic       step;
  logic [5:0] digit;

  assign step  = in_valid && advance;
  assign digit = digit_value(in_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_NORMAL;
      partial_hex <= 8'h00;
    end else if (step) begin
      mode        <= mode_next;
      partial_hex <= partial_hex_next;
    end
  end

  always_comb begin
    mode_next        = MODE_NORMAL;
    partial_hex_next = partial_hex;
    res.emit         = 1'b0;
    res.data         = in_byte;
    res.last         = 1'b0;
    if (in_byte == CHAR_NUL) begin
      partial_hex_next = 8'h00;
      res.emit         = 1'b1;
      res.data         = 8'h00;
      res.last         = 1'b1;
    end else begin
      unique case (mode)
        MODE_ESCAPE: begin
          res.emit = 1'b1;
          unique case (in_byte)
            CHAR_X: begin
              mode_next = MODE_HEX_HI;
              res.emit  = 1'b0;
            end
            CHAR_BACKSLASH: res.data = CHAR_BACKSLASH;
            CHAR_CARET:     res.data = CHAR_CARET;
            CHAR_S:         res.data = BYTE_SPACE;
            CHAR_E:         res.data = BYTE_ESC;
            CHAR_B:         res.data = BYTE_BS;
            CHAR_N:         res.data = BYTE_LF;
            CHAR_R:         res.data = BYTE_CR;
            CHAR_T:         res.data = BYTE_TAB;
            default:        res.emit = 1'b0;
          endcase
        end
        MODE_HEX_HI: begin
          partial_hex_next = {digit[3:0], 4'h0};
          mode_next        = MODE_HEX_LO;
        end
        MODE_HEX_LO: begin
          partial_hex_next = 8'h00;
          res.emit         = 1'b1;
          res.data         = partial_hex + {2'b00, digit};
        end
        MODE_CARET: begin
          res.emit = 1'b1;
          res.data = {3'b000, in_byte[4:0]};
        end
        default: begin
          if (in_byte == CHAR_BACKSLASH) begin
            mode_next = MODE_ESCAPE;
          end else if (in_byte == CHAR_CARET) begin
            mode_next = MODE_CARET;
          end else begin
            res.emit = 1'b1;
          end
        end
      endcase
    end
    res.emit = res.emit && in_valid;
  end

endmodule

/* hdl/esd_out_stage.sv */
`timescale 1ns / 1ps

module esd_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  esd_pkg::result_t res,
  output logic             advance,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,
  output logic             m_tlast
);

  import esd_pkg::*;

  assign advance = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) begin
      m_tdata <= res.data;
      m_tlast <= res.last;
    end
  end

endmodule

/* hdl/esd_checker.sv */
`timescale 1ns / 1ps
`include "escape_sequence_decoder_macros.svh"

module esd_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [7:0] s_tdata,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  // terminator carries a zero byte
  `ESD_ASSERT_SAME(a_last_zero, m_tvalid && m_tlast, m_tdata == 8'h00, "terminator with data")

  // stalled output transfer holds
  `ESD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output changed under stall")

  // stalled input transfer holds
  `ESD_ASSERT_NEXT(a_in_hold, s_tvalid && !s_tready, s_tvalid && $stable(s_tdata), "input changed under stall")

  // nothing offered right after reset
  `ESD_ASSERT_NEXT_ALWAYS(a_reset_empty, rst, !m_tvalid, "output valid after reset")

endmodule

bind escape_sequence_decoder esd_checker u_esd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
